### hdl/ideabc_pkg.sv
package ideabc_pkg;

    localparam int ROUNDS_DEF  = 8;
    localparam int STORE_DEPTH = 52;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int WORD_W      = 16;
    localparam int BLOCK_W     = 64;
    localparam int KEY_W       = 128;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 64;

    localparam logic [1:0] REG_KEY_HIGH     = 2'd0;
    localparam logic [1:0] REG_KEY_LOW      = 2'd1;
    localparam logic [1:0] REG_DECRYPT_MODE = 2'd2;

    localparam logic [1:0] OP_COPY = 2'd0;
    localparam logic [1:0] OP_NEG  = 2'd1;
    localparam logic [1:0] OP_INV  = 2'd2;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } ram_wr_t;

    function automatic logic [WORD_W:0] mm_ext(input logic [WORD_W-1:0] v);
        mm_ext = (v == '0) ? {1'b1, {WORD_W{1'b0}}} : {1'b0, v};
    endfunction

    function automatic logic [WORD_W-1:0] mm_reduce(input logic [2*WORD_W:0] p);
        logic [WORD_W+1:0] d;
        d = {2'b00, p[WORD_W-1:0]} - {1'b0, p[2*WORD_W:WORD_W]};
        if (d[WORD_W+1])
        begin
            d = d + {2'b01, {(WORD_W-1){1'b0}}, 1'b1};
        end
        mm_reduce = d[WORD_W-1:0];
    endfunction

endpackage

### hdl/idea_block_cipher_top.sv
// IDEA block cipher, 128-bit key, one 64-bit block per request beat.
// Configuration: APB-style port, registers at byte addresses 0x00 key_high,
// 0x08 key_low, 0x10 decrypt_mode; writes complete in the access cycle.
// Any register write rebuilds the 52-entry subkey memory; req_ready stays
// low until the rebuild is finished. A decrypt rebuild also computes each
// of the 2*ROUNDS+2 multiplicative inverses (square-and-multiply on one
// 17x17 multiplier).
// Data: req_valid/req_ready carry block_in, rsp_valid/rsp_ready carry
// block_out. One block is processed at a time: each subkey is read from the
// subkey memory and then applied, and a new block is accepted only after
// the previous one has finished. The result sits in an output register; the
// next block is accepted while it waits. If the receiver stalls, a finished
// block holds in the core until the output register frees.
// Reset clears the configuration registers to zero and starts a rebuild for the zero key.
module idea_block_cipher_top #(
    parameter int ROUNDS = ideabc_pkg::ROUNDS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ideabc_pkg::PADDR_W-1:0] paddr,
    input  logic [ideabc_pkg::PDATA_W-1:0] pwdata,
    output logic [ideabc_pkg::PDATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  logic [ideabc_pkg::BLOCK_W-1:0] block_in,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output logic [ideabc_pkg::BLOCK_W-1:0] block_out
);
    import ideabc_pkg::*;

    logic [63:0]       key_high_reg;
    logic [63:0]       key_low_reg;
    logic              decrypt_mode_reg;
    logic [1:0]        reg_idx;
    logic              wr_en;
    logic              restart;
    logic              sched_busy;
    ram_wr_t           wr;
    logic [ADDR_W-1:0] raddr;
    logic [WORD_W-1:0] rdata;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr_en   = psel && penable && pwrite;
    assign restart = wr_en && (reg_idx == REG_KEY_HIGH || reg_idx == REG_KEY_LOW ||
                               reg_idx == REG_DECRYPT_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg     <= '0;
            key_low_reg      <= '0;
            decrypt_mode_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_KEY_HIGH:     key_high_reg     <= pwdata;
                REG_KEY_LOW:      key_low_reg      <= pwdata;
                REG_DECRYPT_MODE: decrypt_mode_reg <= pwdata[0];
                default:          key_high_reg     <= key_high_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_KEY_HIGH:     prdata = key_high_reg;
            REG_KEY_LOW:      prdata = key_low_reg;
            REG_DECRYPT_MODE: prdata = {63'd0, decrypt_mode_reg};
            default:          prdata = '0;
        endcase
    end

    ideabc_ksched #(.ROUNDS(ROUNDS)) u_ksched (
        .clk     (clk),
        .rst_n   (rst_n),
        .key     ({key_high_reg, key_low_reg}),
        .decrypt (decrypt_mode_reg),
        .restart (restart),
        .busy    (sched_busy),
        .wr      (wr)
    );

    ideabc_ram #(.WIDTH(WORD_W), .DEPTH(STORE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (wr.we),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (raddr),
        .rdata (rdata)
    );

    ideabc_core #(.ROUNDS(ROUNDS)) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .sched_busy (sched_busy),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .block_in   (block_in),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .block_out  (block_out),
        .raddr      (raddr),
        .rdata      (rdata)
    );
endmodule

### hdl/ideabc_ram.sv
module ideabc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 52
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### hdl/ideabc_ksched.sv
module ideabc_ksched #(
    parameter int ROUNDS = ideabc_pkg::ROUNDS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [ideabc_pkg::KEY_W-1:0] key,
    input  logic                         decrypt,
    input  logic                         restart,
    output logic                         busy,
    output ideabc_pkg::ram_wr_t          wr
);
    import ideabc_pkg::*;

    localparam int USED  = 6 * ROUNDS + 4;
    localparam int IBASE0 = 6 * (ROUNDS - 1);
    localparam logic [1:0] S_LOAD = 2'd0;
    localparam logic [1:0] S_GEN  = 2'd1;
    localparam logic [1:0] S_INV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]        state_reg;
    logic [KEY_W-1:0]  keyrot_reg;
    logic [ADDR_W-1:0] k_reg;
    logic [2:0]        t_reg;
    logic [ADDR_W-1:0] ibase_reg;
    logic [ADDR_W-1:0] dest_reg;
    logic [WORD_W:0]   base_reg;
    logic [WORD_W:0]   acc_reg;
    logic [2*WORD_W:0] prod_reg;
    logic [3:0]        it_reg;
    logic [1:0]        sp_reg;

    logic [WORD_W-1:0] word;
    logic [6:0]        sh;
    logic              head;
    logic              tail;
    logic [ADDR_W-1:0] dest;
    logic [1:0]        op;
    logic              inv_last;
    logic              advance;

    assign sh   = {3'd7 - k_reg[2:0], 4'b0000};
    assign word = WORD_W'(keyrot_reg >> sh);
    assign head = (k_reg < ADDR_W'(4));
    assign tail = (k_reg >= ADDR_W'(USED));
    assign inv_last = (state_reg == S_INV) && (sp_reg == 2'd3) && (it_reg == 4'd14);
    assign advance  = ((state_reg == S_GEN) && (op != OP_INV)) || inv_last;
    assign busy = (state_reg != S_DONE);

    always_comb
    begin
        dest = k_reg;
        op   = OP_COPY;
        if (decrypt && !tail)
        begin
            if (head)
            begin
                dest = ADDR_W'(6 * ROUNDS) + k_reg;
                op   = (k_reg[1:0] == 2'd0 || k_reg[1:0] == 2'd3) ? OP_INV : OP_NEG;
            end
            else
            begin
                case (t_reg)
                    3'd0:
                    begin
                        dest = ibase_reg + ADDR_W'(4);
                        op   = OP_COPY;
                    end
                    3'd1:
                    begin
                        dest = ibase_reg + ADDR_W'(5);
                        op   = OP_COPY;
                    end
                    3'd2:
                    begin
                        dest = ibase_reg;
                        op   = OP_INV;
                    end
                    3'd3:
                    begin
                        dest = ibase_reg + ((ibase_reg != '0) ? ADDR_W'(2) : ADDR_W'(1));
                        op   = OP_NEG;
                    end
                    3'd4:
                    begin
                        dest = ibase_reg + ((ibase_reg != '0) ? ADDR_W'(1) : ADDR_W'(2));
                        op   = OP_NEG;
                    end
                    3'd5:
                    begin
                        dest = ibase_reg + ADDR_W'(3);
                        op   = OP_INV;
                    end
                    default:
                    begin
                        dest = k_reg;
                        op   = OP_COPY;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        wr.we   = advance;
        wr.addr = (state_reg == S_GEN) ? dest : dest_reg;
        if (state_reg == S_GEN)
        begin
            wr.data = (op == OP_NEG) ? WORD_W'(16'd0 - word) : word;
        end
        else
        begin
            wr.data = mm_reduce(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            k_reg     <= '0;
            t_reg     <= '0;
            ibase_reg <= '0;
            it_reg    <= '0;
            sp_reg    <= '0;
        end
        else if (restart)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            case (state_reg)
                S_LOAD:
                begin
                    k_reg     <= '0;
                    t_reg     <= '0;
                    ibase_reg <= ADDR_W'(IBASE0);
                    state_reg <= S_GEN;
                end
                S_GEN:
                begin
                    if (op == OP_INV)
                    begin
                        it_reg    <= '0;
                        sp_reg    <= '0;
                        state_reg <= S_INV;
                    end
                end
                S_INV:
                begin
                    sp_reg <= sp_reg + 2'd1;
                    if (sp_reg == 2'd3 && !inv_last)
                    begin
                        it_reg <= it_reg + 4'd1;
                    end
                end
                default:
                begin
                    state_reg <= S_DONE;
                end
            endcase
            if (advance)
            begin
                k_reg <= k_reg + ADDR_W'(1);
                if (!head && !tail)
                begin
                    if (t_reg == 3'd5)
                    begin
                        t_reg     <= '0;
                        ibase_reg <= ibase_reg - ADDR_W'(6);
                    end
                    else
                    begin
                        t_reg <= t_reg + 3'd1;
                    end
                end
                state_reg <= (k_reg == ADDR_W'(STORE_DEPTH - 1)) ? S_DONE : S_GEN;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD)
        begin
            keyrot_reg <= key;
        end
        else if (advance && k_reg[2:0] == 3'd7)
        begin
            keyrot_reg <= {keyrot_reg[KEY_W-26:0], keyrot_reg[KEY_W-1:KEY_W-25]};
        end
        if (state_reg == S_GEN)
        begin
            base_reg <= mm_ext(word);
            acc_reg  <= mm_ext(word);
            dest_reg <= dest;
        end
        else if (state_reg == S_INV)
        begin
            case (sp_reg)
                2'd0:    prod_reg <= (2*WORD_W+1)'(acc_reg * acc_reg);
                2'd2:    prod_reg <= (2*WORD_W+1)'(acc_reg * base_reg);
                default: acc_reg  <= mm_ext(mm_reduce(prod_reg));
            endcase
        end
    end
endmodule

### hdl/ideabc_core.sv
module ideabc_core #(
    parameter int ROUNDS = ideabc_pkg::ROUNDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sched_busy,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [ideabc_pkg::BLOCK_W-1:0] block_in,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [ideabc_pkg::BLOCK_W-1:0] block_out,
    output logic [ideabc_pkg::ADDR_W-1:0]  raddr,
    input  logic [ideabc_pkg::WORD_W-1:0]  rdata
);
    import ideabc_pkg::*;

    localparam int RW = $clog2(ROUNDS + 1);
    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_RUN  = 2'd1;
    localparam logic [1:0] C_DONE = 2'd2;

    logic [1:0]         state_reg;
    logic               ph_reg;
    logic [ADDR_W-1:0]  k_reg;
    logic [2:0]         t_reg;
    logic [RW-1:0]      rnd_reg;
    logic [WORD_W-1:0]  x0_reg, x1_reg, x2_reg, x3_reg, t0_reg, key_reg;
    logic [2*WORD_W:0]  prod_reg;
    logic               rsp_valid_reg;
    logic [BLOCK_W-1:0] block_out_reg;

    logic               final_tr;
    logic               last_step;
    logic               accept;
    logic               load_out;
    logic [WORD_W-1:0]  opa;
    logic [WORD_W-1:0]  mr;
    logic [WORD_W-1:0]  mix_t0;

    assign final_tr  = (rnd_reg == RW'(ROUNDS));
    assign last_step = final_tr && (t_reg == 3'd3);
    assign req_ready = (state_reg == C_IDLE) && !sched_busy;
    assign accept    = req_valid && req_ready;
    assign load_out  = (state_reg == C_DONE) && (!rsp_valid_reg || rsp_ready);
    assign mr        = mm_reduce(prod_reg);
    assign mix_t0    = t0_reg + mr;
    assign rsp_valid = rsp_valid_reg;
    assign block_out = block_out_reg;

    always_comb
    begin
        if (state_reg != C_RUN)
        begin
            raddr = '0;
        end
        else if (ph_reg && !last_step)
        begin
            raddr = k_reg + ADDR_W'(1);
        end
        else
        begin
            raddr = k_reg;
        end
    end

    always_comb
    begin
        case (t_reg)
            3'd3:    opa = x3_reg;
            3'd4:    opa = x0_reg ^ x2_reg;
            3'd5:    opa = t0_reg + (x1_reg ^ x3_reg);
            default: opa = x0_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_IDLE;
            ph_reg        <= 1'b0;
            k_reg         <= '0;
            t_reg         <= '0;
            rnd_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                C_IDLE:
                begin
                    if (accept)
                    begin
                        ph_reg    <= 1'b0;
                        k_reg     <= '0;
                        t_reg     <= '0;
                        rnd_reg   <= '0;
                        state_reg <= C_RUN;
                    end
                end
                C_RUN:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        k_reg <= k_reg + ADDR_W'(1);
                        if (!final_tr && t_reg == 3'd5)
                        begin
                            t_reg   <= '0;
                            rnd_reg <= rnd_reg + RW'(1);
                        end
                        else
                        begin
                            t_reg <= t_reg + 3'd1;
                        end
                        if (last_step)
                        begin
                            state_reg <= C_DONE;
                        end
                    end
                end
                C_DONE:
                begin
                    if (load_out)
                    begin
                        state_reg <= C_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x0_reg <= block_in[63:48];
            x1_reg <= block_in[47:32];
            x2_reg <= block_in[31:16];
            x3_reg <= block_in[15:0];
        end
        else if (state_reg == C_RUN && !ph_reg)
        begin
            prod_reg <= (2*WORD_W+1)'(mm_ext(opa) * mm_ext(rdata));
            key_reg  <= rdata;
        end
        else if (state_reg == C_RUN)
        begin
            case (t_reg)
                3'd0: x0_reg <= mr;
                3'd1:
                begin
                    if (final_tr)
                    begin
                        x2_reg <= x2_reg + key_reg;
                    end
                    else
                    begin
                        x1_reg <= x1_reg + key_reg;
                    end
                end
                3'd2:
                begin
                    if (final_tr)
                    begin
                        x1_reg <= x1_reg + key_reg;
                    end
                    else
                    begin
                        x2_reg <= x2_reg + key_reg;
                    end
                end
                3'd3: x3_reg <= mr;
                3'd4: t0_reg <= mr;
                3'd5:
                begin
                    x0_reg <= x0_reg ^ mr;
                    x3_reg <= x3_reg ^ mix_t0;
                    x1_reg <= x2_reg ^ mr;
                    x2_reg <= mix_t0 ^ x1_reg;
                end
                default: t0_reg <= t0_reg;
            endcase
        end
        if (load_out)
        begin
            block_out_reg <= {x0_reg, x2_reg, x1_reg, x3_reg};
        end
    end
endmodule

### hdl/ideabc_checker.sv
module ideabc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [ideabc_pkg::PADDR_W-1:0] paddr,
    input logic                           pready,
    input logic                           req_valid,
    input logic                           req_ready,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [ideabc_pkg::BLOCK_W-1:0] block_out
);
    import ideabc_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(block_out))
        else $error("result beat dropped or changed while stalled");

    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr[4:3] != 2'd3 |=> !req_ready)
        else $error("request taken while subkeys rebuild");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second block taken while one is in flight");

    a_no_early_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(rsp_valid))
        else $error("result appeared right after accept");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");
endmodule

bind idea_block_cipher_top ideabc_checker u_chk (.*);
